// ----- rtl/dmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_pkg
// Types and constants shared by the DNS message parser.
// ----------------------------------------------------------------------------
package dmp_pkg;

    localparam int          NAME_LIMIT_DEF   = 256;
    localparam logic [15:0] WANTED_QTYPE_RST = 16'd28;
    localparam logic [15:0] TYPE_AAAA        = 16'd28;
    localparam logic [7:0]  PTR_MARK         = 8'hC0;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_NOTIMP = 2'd2;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RESPONSE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } dmp_in_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [15:0] qtype;
        logic [16:0] ttl_offset;
        logic [31:0] ttl;
        logic [31:0] min_ttl;
        logic        first_is_aaaa;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic        last;
    } dmp_out_t;

endpackage

// ----- rtl/dns_message_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_message_parser
// Parses a TCP-framed DNS message one byte per item; emits record and final
// results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_item (dmp_in_t)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_item (dmp_out_t)
//  cfg     | in        | cfg_we             | cfg_wdata (wanted qtype)
//
// One byte is taken per cycle while req_stall is low; its state update is a single combinational
// pass into the parse registers and a three-entry result queue.
// A byte that closes both a record and the message yields two results, so
// the request side stalls while two or more results are queued.
// Reset clears all parse state and the queue; wanted qtype returns to AAAA.
// ----------------------------------------------------------------------------
module dns_message_parser
    import dmp_pkg::*;
#(
    parameter int NAME_LIMIT = NAME_LIMIT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dmp_in_t  req_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output dmp_out_t rsp_item,
    input  logic     cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int NLW = $clog2(NAME_LIMIT + 1);
    localparam int SW  = NLW + 9;

    typedef enum logic [3:0] {
        P_LEN_HI, P_LEN_LO, P_HEADER, P_QLEN, P_QTEXT, P_QFIXED, P_RFIRST,
        P_RPTR, P_RLEN, P_RTEXT, P_RFIXED, P_RDATA, P_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] mlen_reg, mlen_next;
    logic [31:0] fs_reg, fs_next;
    logic [17:0] rl_reg, rl_next;
    logic [15:0] skip_reg, skip_next;
    logic [NLW-1:0] nl_reg, nl_next;
    logic [15:0] hc_reg [4];
    logic [15:0] hc_next [4];
    logic [31:0] lt_reg, lt_next;
    logic [63:0] ah_reg, ah_next, al_reg, al_next;
    logic        err_reg, err_next;
    logic [15:0] qt_reg, qt_next, rt_reg, rt_next;
    logic [31:0] rttl_reg, rttl_next;
    logic [16:0] rtp_reg, rtp_next;
    logic [4:0]  ac_reg, ac_next;
    logic        isf_reg, isf_next, fa_reg, fa_next;
    logic [15:0] wanted_reg;

    dmp_out_t    q_reg [3];
    dmp_out_t    q_next [3];
    logic [1:0]  cnt_reg, cnt_next;

    logic        accept, deq;
    logic        rec_emit, fin_emit;
    logic [1:0]  fin_status;
    dmp_out_t    rec_res, fin_res;

    assign req_stall = cnt_reg >= 2'd2;
    assign rsp_valid = cnt_reg != 2'd0;
    assign rsp_item  = q_reg[0];
    assign accept    = req_valid && !req_stall;
    assign deq       = rsp_valid && !rsp_stall;

    // parse step for one byte
    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  h;
        logic [1:0]  hi;
        logic        do_label;
        phase_t      zero_ph, text_ph;
        logic [17:0] end_chk;
        logic [SW-1:0] nsum;
        logic [15:0] idx;
        logic [15:0] rdlen;
        b          = req_item.data_byte;
        h          = 4'd0;
        hi         = 2'd0;
        do_label   = 1'b0;
        zero_ph    = P_QFIXED;
        text_ph    = P_QTEXT;
        end_chk    = 18'd0;
        nsum       = '0;
        idx        = skip_reg;
        rdlen      = 16'd0;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        mlen_next  = mlen_reg;
        fs_next    = fs_reg;
        rl_next    = rl_reg;
        skip_next  = skip_reg;
        nl_next    = nl_reg;
        for (int i = 0; i < 4; i++)
        begin
            hc_next[i] = hc_reg[i];
        end
        lt_next    = lt_reg;
        ah_next    = ah_reg;
        al_next    = al_reg;
        err_next   = err_reg;
        qt_next    = qt_reg;
        rt_next    = rt_reg;
        rttl_next  = rttl_reg;
        rtp_next   = rtp_reg;
        ac_next    = ac_reg;
        isf_next   = isf_reg;
        fa_next    = fa_reg;
        rec_emit   = 1'b0;
        fin_emit   = 1'b0;
        fin_status = ST_OK;

        if (phase_reg == P_LEN_HI)
        begin
            kind_next  = req_item.cmd;
            mlen_next  = {b, 8'd0};
            fs_next    = '0;
            rl_next    = '0;
            skip_next  = '0;
            nl_next    = '0;
            for (int i = 0; i < 4; i++)
            begin
                hc_next[i] = '0;
            end
            lt_next    = '0;
            ah_next    = '0;
            al_next    = '0;
            err_next   = 1'b0;
            qt_next    = '0;
            rt_next    = '0;
            rttl_next  = '0;
            rtp_next   = '0;
            ac_next    = '0;
            isf_next   = 1'b0;
            fa_next    = 1'b0;
            phase_next = P_LEN_LO;
            pos_next   = 17'd1;
        end
        else if (phase_reg == P_LEN_LO)
        begin
            mlen_next = {mlen_reg[15:8], b};
            if ({mlen_reg[15:8], b} == 16'd0)
            begin
                err_next   = 1'b1;
                fin_emit   = 1'b1;
                fin_status = ST_FORMAT;
                phase_next = P_LEN_HI;
                pos_next   = '0;
            end
            else
            begin
                phase_next = P_HEADER;
                skip_next  = '0;
                pos_next   = 17'd2;
            end
        end
        else
        begin
            case (phase_reg)
                P_HEADER:
                begin
                    h = 4'(pos_reg - 17'd2);
                    if (h >= 4'd4)
                    begin
                        hi = 2'((h - 4'd4) >> 1);
                        hc_next[hi] = {hc_reg[hi][7:0], b};
                    end
                    if (h >= 4'd11)
                    begin
                        if (kind_reg == CMD_RESPONSE && hc_next[0] != 16'd1)
                        begin
                            err_next   = 1'b1;
                            phase_next = P_DONE;
                        end
                        else
                        begin
                            phase_next = P_QLEN;
                            nl_next    = '0;
                        end
                    end
                end
                P_QLEN:
                begin
                    do_label = 1'b1;
                end
                P_QTEXT, P_RTEXT:
                begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_next == 16'd0)
                    begin
                        phase_next = (phase_reg == P_QTEXT) ? P_QLEN : P_RLEN;
                    end
                end
                P_QFIXED:
                begin
                    if (skip_reg < 16'd2)
                    begin
                        qt_next = {qt_reg[7:0], b};
                    end
                    skip_next = skip_reg + 16'd1;
                    if (skip_next == 16'd4)
                    begin
                        if (kind_reg == CMD_RESPONSE && hc_reg[1] != 16'd0)
                        begin
                            rl_next = 18'(hc_reg[1]) + 18'(hc_reg[2]) + 18'(hc_reg[3]);
                            isf_next   = 1'b1;
                            phase_next = P_RFIRST;
                            nl_next    = '0;
                        end
                        else
                        begin
                            phase_next = P_DONE;
                        end
                    end
                end
                P_RFIRST:
                begin
                    if ((b & PTR_MARK) == PTR_MARK)
                    begin
                        phase_next = P_RPTR;
                    end
                    else if ((b & PTR_MARK) == 8'd0)
                    begin
                        do_label = 1'b1;
                    end
                    else
                    begin
                        err_next   = 1'b1;
                        phase_next = P_DONE;
                    end
                end
                P_RPTR:
                begin
                    phase_next = P_RFIXED;
                    skip_next  = '0;
                    fs_next    = '0;
                end
                P_RLEN:
                begin
                    do_label = 1'b1;
                end
                P_RFIXED:
                begin
                    fs_next = {fs_reg[23:0], b};
                    if (idx == 16'd1)
                    begin
                        rt_next = fs_next[15:0];
                        fs_next = '0;
                    end
                    if (idx == 16'd3)
                    begin
                        fs_next = '0;
                    end
                    if (idx == 16'd4)
                    begin
                        rtp_next = pos_reg;
                    end
                    if (idx == 16'd7)
                    begin
                        rttl_next = fs_next;
                        fs_next   = '0;
                    end
                    skip_next = skip_reg + 16'd1;
                    if (idx == 16'd9)
                    begin
                        rdlen   = fs_next[15:0];
                        fs_next = '0;
                        rl_next = rl_reg - 18'd1;
                        if (isf_reg)
                        begin
                            lt_next = rttl_reg;
                            fa_next = (rt_reg == TYPE_AAAA);
                        end
                        else if (rttl_reg != 32'd0 && rttl_reg < lt_reg)
                        begin
                            lt_next = rttl_reg;
                        end
                        rec_emit = 1'b1;
                        if (rdlen != 16'd0)
                        begin
                            phase_next = P_RDATA;
                            skip_next  = rdlen;
                            ac_next    = '0;
                        end
                        else
                        begin
                            isf_next = 1'b0;
                            if (rl_next == 18'd0)
                            begin
                                phase_next = P_DONE;
                            end
                            else
                            begin
                                phase_next = P_RFIRST;
                                nl_next    = '0;
                            end
                        end
                    end
                end
                P_RDATA:
                begin
                    if (isf_reg && fa_reg && ac_reg < 5'd16)
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            if (ac_reg[2:0] == 3'(k))
                            begin
                                if (ac_reg[3])
                                begin
                                    al_next[(7-k)*8 +: 8] = al_reg[(7-k)*8 +: 8] | b;
                                end
                                else
                                begin
                                    ah_next[(7-k)*8 +: 8] = ah_reg[(7-k)*8 +: 8] | b;
                                end
                            end
                        end
                        ac_next = ac_reg + 5'd1;
                    end
                    skip_next = skip_reg - 16'd1;
                    if (skip_next == 16'd0)
                    begin
                        isf_next = 1'b0;
                        if (rl_reg == 18'd0)
                        begin
                            phase_next = P_DONE;
                        end
                        else
                        begin
                            phase_next = P_RFIRST;
                            nl_next    = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // label length byte of the question or a record owner
            if (do_label)
            begin
                if (phase_reg == P_QLEN)
                begin
                    zero_ph = P_QFIXED;
                    text_ph = P_QTEXT;
                end
                else
                begin
                    zero_ph = P_RFIXED;
                    text_ph = P_RTEXT;
                end
                end_chk = {1'b0, pos_reg} + 18'd1 + 18'(b);
                nsum    = SW'(nl_reg) + SW'(b) + SW'(1);
                if (b == 8'd0)
                begin
                    phase_next = zero_ph;
                    skip_next  = '0;
                    fs_next    = '0;
                end
                else if (end_chk > ({2'b00, mlen_reg} + 18'd2) || nsum >= SW'(NAME_LIMIT))
                begin
                    err_next   = 1'b1;
                    phase_next = P_DONE;
                end
                else
                begin
                    nl_next    = nsum[NLW-1:0];
                    skip_next  = 16'(b);
                    phase_next = text_ph;
                end
            end

            if ({1'b0, pos_reg} == {2'b00, mlen_reg} + 18'd1)
            begin
                fin_emit = 1'b1;
                if (err_next)
                begin
                    fin_status = ST_FORMAT;
                end
                else if (kind_reg == CMD_REQUEST)
                begin
                    if (phase_next != P_DONE)
                    begin
                        fin_status = ST_FORMAT;
                    end
                    else if (qt_next != wanted_reg)
                    begin
                        fin_status = ST_NOTIMP;
                    end
                    else
                    begin
                        fin_status = ST_OK;
                    end
                end
                else if (phase_next == P_DONE || (phase_next == P_RDATA && rl_next == 18'd0))
                begin
                    fin_status = ST_OK;
                end
                else
                begin
                    fin_status = ST_FORMAT;
                end
                phase_next = P_LEN_HI;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 17'd1;
            end
        end
    end

    always_comb
    begin
        rec_res.kind          = KIND_RECORD;
        rec_res.status        = ST_OK;
        rec_res.qtype         = qt_next;
        rec_res.ttl_offset    = rtp_next;
        rec_res.ttl           = rttl_next;
        rec_res.min_ttl       = lt_next;
        rec_res.first_is_aaaa = fa_next;
        rec_res.addr_high     = '0;
        rec_res.addr_low      = '0;
        rec_res.last          = !fin_emit;

        fin_res.kind          = KIND_FINAL;
        fin_res.status        = fin_status;
        fin_res.qtype         = qt_next;
        fin_res.ttl_offset    = '0;
        fin_res.ttl           = '0;
        fin_res.min_ttl       = lt_next;
        fin_res.first_is_aaaa = fa_next;
        fin_res.addr_high     = ah_next;
        fin_res.addr_low      = al_next;
        fin_res.last          = 1'b1;
    end

    // result queue: head at entry 0, shift on take
    always_comb
    begin
        logic [1:0] base;
        base = cnt_reg - {1'b0, deq};
        if (deq)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            q_next[2] = q_reg[2];
        end
        else
        begin
            q_next[0] = q_reg[0];
            q_next[1] = q_reg[1];
            q_next[2] = q_reg[2];
        end
        cnt_next = base;
        if (accept)
        begin
            if (rec_emit && fin_emit)
            begin
                q_next[base]        = rec_res;
                q_next[base + 2'd1] = fin_res;
                cnt_next            = base + 2'd2;
            end
            else if (rec_emit)
            begin
                q_next[base] = rec_res;
                cnt_next     = base + 2'd1;
            end
            else if (fin_emit)
            begin
                q_next[base] = fin_res;
                cnt_next     = base + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= WANTED_QTYPE_RST;
            cnt_reg    <= '0;
            phase_reg  <= P_LEN_HI;
            kind_reg   <= 1'b0;
            pos_reg    <= '0;
            mlen_reg   <= '0;
            fs_reg     <= '0;
            rl_reg     <= '0;
            skip_reg   <= '0;
            nl_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                hc_reg[i] <= '0;
            end
            lt_reg     <= '0;
            ah_reg     <= '0;
            al_reg     <= '0;
            err_reg    <= 1'b0;
            qt_reg     <= '0;
            rt_reg     <= '0;
            rttl_reg   <= '0;
            rtp_reg    <= '0;
            ac_reg     <= '0;
            isf_reg    <= 1'b0;
            fa_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wanted_reg <= cfg_wdata;
            end
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                pos_reg   <= pos_next;
                mlen_reg  <= mlen_next;
                fs_reg    <= fs_next;
                rl_reg    <= rl_next;
                skip_reg  <= skip_next;
                nl_reg    <= nl_next;
                for (int i = 0; i < 4; i++)
                begin
                    hc_reg[i] <= hc_next[i];
                end
                lt_reg    <= lt_next;
                ah_reg    <= ah_next;
                al_reg    <= al_next;
                err_reg   <= err_next;
                qt_reg    <= qt_next;
                rt_reg    <= rt_next;
                rttl_reg  <= rttl_next;
                rtp_reg   <= rtp_next;
                ac_reg    <= ac_next;
                isf_reg   <= isf_next;
                fa_reg    <= fa_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives framed DNS messages into the parser one byte at a time and checks
// every record and final result against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module testbench;
    import dmp_pkg::*;

    typedef enum logic [3:0] {
        PH_LEN_HI, PH_LEN_LO, PH_HEADER, PH_QLEN, PH_QTEXT, PH_QFIXED, PH_RFIRST,
        PH_RPTR, PH_RLEN, PH_RTEXT, PH_RFIXED, PH_RDATA, PH_DONE
    } parse_phase_t;

    localparam int FL_CLEAN     = 0;
    localparam int FL_NOISY     = 1;
    localparam int FL_BAD_OWNER = 2;
    localparam int FL_LONG_NAME = 3;
    localparam int FL_TRUNCATE  = 4;
    localparam int FL_NO_QUEST  = 5;

    localparam int ITEM_TARGET = 1650;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;

    class parse_scoreboard;
        dmp_out_t     due[$];
        dmp_out_t     step_out[$];
        int           errors;
        int           records_seen;
        int           finals_seen;
        logic [15:0]  wanted;
        parse_phase_t phase;
        bit           msg_kind;
        bit           first_rec;
        bit           first_aaaa;
        int unsigned  pos, msg_len, shift, recs_left, skip, name_len, low_ttl;
        int unsigned  err_flag, q_type, rec_type, rec_ttl, ttl_pos, addr_cnt;
        int unsigned  hdr[4];
        logic [63:0]  addr[2];

        function new();
            wanted = WANTED_QTYPE_RST;
            clear_message(1'b0);
            phase = PH_LEN_HI;
            pos = 0;
        endfunction

        function void clear_message(bit k);
            msg_kind = k;
            msg_len = 0; shift = 0; recs_left = 0; skip = 0; name_len = 0;
            hdr = '{0, 0, 0, 0};
            low_ttl = 0;
            addr = '{64'd0, 64'd0};
            err_flag = 0;
            q_type = 0; rec_type = 0; rec_ttl = 0; ttl_pos = 0; addr_cnt = 0;
            first_rec = 0;
            first_aaaa = 0;
        endfunction

        function void emit(bit k, logic [1:0] st, int unsigned toff, int unsigned ttlv,
                           logic [63:0] hi, logic [63:0] lo);
            dmp_out_t r;
            r.kind          = k;
            r.status        = st;
            r.qtype         = q_type[15:0];
            r.ttl_offset    = toff[16:0];
            r.ttl           = ttlv;
            r.min_ttl       = low_ttl;
            r.first_is_aaaa = first_aaaa;
            r.addr_high     = hi;
            r.addr_low      = lo;
            r.last          = 1'b0;
            step_out.push_back(r);
        endfunction

        function void bad_format();
            err_flag = 1;
            phase = PH_DONE;
        endfunction

        function void take_label(int unsigned b, int unsigned p, parse_phase_t zero_ph,
                                 parse_phase_t text_ph);
            if (b == 0)
            begin
                phase = zero_ph;
                skip = 0;
                shift = 0;
            end
            else if (p + 1 + b > msg_len + 2 || name_len + b + 1 >= NAME_LIMIT_DEF)
            begin
                bad_format();
            end
            else
            begin
                name_len += b + 1;
                skip = b;
                phase = text_ph;
            end
        endfunction

        function void advance_record();
            if (recs_left == 0)
            begin
                phase = PH_DONE;
            end
            else
            begin
                phase = PH_RFIRST;
                name_len = 0;
            end
        endfunction

        function void note_byte(dmp_in_t it);
            int unsigned b, p, h, idx, rdlen;
            logic [1:0]  st;
            b = 32'(it.data_byte);
            p = pos;
            step_out.delete();
            if (phase == PH_LEN_HI)
            begin
                clear_message(it.cmd);
                msg_len = b << 8;
                phase = PH_LEN_LO;
                pos = 1;
                return;
            end
            if (phase == PH_LEN_LO)
            begin
                msg_len |= b;
                if (msg_len == 0)
                begin
                    err_flag = 1;
                    emit(KIND_FINAL, ST_FORMAT, 0, 0, addr[0], addr[1]);
                    step_out[0].last = 1'b1;
                    due.push_back(step_out[0]);
                    phase = PH_LEN_HI;
                    pos = 0;
                end
                else
                begin
                    phase = PH_HEADER;
                    skip = 0;
                    pos = 2;
                end
                return;
            end
            case (phase)
                PH_HEADER:
                begin
                    h = p - 2;
                    if (h >= 4 && h < 12)
                        hdr[(h - 4) >> 1] = ((hdr[(h - 4) >> 1] << 8) | b) & 16'hFFFF;
                    if (h >= 11)
                    begin
                        if (msg_kind == CMD_RESPONSE && hdr[0] != 1)
                        begin
                            bad_format();
                        end
                        else
                        begin
                            phase = PH_QLEN;
                            name_len = 0;
                        end
                    end
                end
                PH_QLEN: take_label(b, p, PH_QFIXED, PH_QTEXT);
                PH_QTEXT, PH_RTEXT:
                begin
                    skip--;
                    if (skip == 0)
                        phase = (phase == PH_QTEXT) ? PH_QLEN : PH_RLEN;
                end
                PH_QFIXED:
                begin
                    if (skip < 2)
                        q_type = ((q_type << 8) | b) & 16'hFFFF;
                    skip++;
                    if (skip == 4)
                    begin
                        if (msg_kind == CMD_RESPONSE && hdr[1] > 0)
                        begin
                            recs_left = hdr[1] + hdr[2] + hdr[3];
                            first_rec = 1;
                            advance_record();
                        end
                        else
                        begin
                            phase = PH_DONE;
                        end
                    end
                end
                PH_RFIRST:
                begin
                    if ((b & PTR_MARK) == PTR_MARK)
                        phase = PH_RPTR;
                    else if ((b & PTR_MARK) == 0)
                        take_label(b, p, PH_RFIXED, PH_RTEXT);
                    else
                        bad_format();
                end
                PH_RPTR:
                begin
                    phase = PH_RFIXED;
                    skip = 0;
                    shift = 0;
                end
                PH_RLEN: take_label(b, p, PH_RFIXED, PH_RTEXT);
                PH_RFIXED:
                begin
                    idx = skip;
                    shift = (shift << 8) | b;
                    if (idx == 1)
                    begin
                        rec_type = shift & 16'hFFFF;
                        shift = 0;
                    end
                    if (idx == 3)
                        shift = 0;
                    if (idx == 4)
                        ttl_pos = p;
                    if (idx == 7)
                    begin
                        rec_ttl = shift;
                        shift = 0;
                    end
                    skip++;
                    if (idx == 9)
                    begin
                        rdlen = shift & 16'hFFFF;
                        shift = 0;
                        recs_left--;
                        if (first_rec)
                        begin
                            low_ttl = rec_ttl;
                            first_aaaa = (rec_type == TYPE_AAAA);
                        end
                        else if (rec_ttl > 0 && rec_ttl < low_ttl)
                        begin
                            low_ttl = rec_ttl;
                        end
                        emit(KIND_RECORD, ST_OK, ttl_pos, rec_ttl, 64'd0, 64'd0);
                        if (rdlen > 0)
                        begin
                            phase = PH_RDATA;
                            skip = rdlen;
                            addr_cnt = 0;
                        end
                        else
                        begin
                            first_rec = 0;
                            advance_record();
                        end
                    end
                end
                PH_RDATA:
                begin
                    if (first_rec && first_aaaa && addr_cnt < 16)
                    begin
                        addr[(addr_cnt >> 3) & 1] |= 64'(b) << ((7 - (addr_cnt & 7)) * 8);
                        addr_cnt++;
                    end
                    skip--;
                    if (skip == 0)
                    begin
                        first_rec = 0;
                        advance_record();
                    end
                end
                default: ;
            endcase
            if (p == msg_len + 1)
            begin
                if (err_flag != 0)
                    st = ST_FORMAT;
                else if (msg_kind == CMD_REQUEST)
                    st = (phase != PH_DONE) ? ST_FORMAT :
                         (q_type[15:0] != wanted ? ST_NOTIMP : ST_OK);
                else
                    st = (phase == PH_DONE || (phase == PH_RDATA && recs_left == 0)) ?
                         ST_OK : ST_FORMAT;
                emit(KIND_FINAL, st, 0, 0, addr[0], addr[1]);
                phase = PH_LEN_HI;
                pos = 0;
            end
            else
            begin
                pos = (p + 1) & 17'h1FFFF;
            end
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i])
                due.push_back(step_out[i]);
        endfunction

        function void compare_field(string nm, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
                errors++;
            end
        endfunction

        function void check_result(dmp_out_t got);
            dmp_out_t exp_r;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = due.pop_front();
            if (got.kind == KIND_FINAL)
                finals_seen++;
            else
                records_seen++;
            compare_field("kind", exp_r.kind, got.kind);
            compare_field("status", exp_r.status, got.status);
            compare_field("qtype", exp_r.qtype, got.qtype);
            compare_field("ttl_offset", exp_r.ttl_offset, got.ttl_offset);
            compare_field("ttl", exp_r.ttl, got.ttl);
            compare_field("min_ttl", exp_r.min_ttl, got.min_ttl);
            compare_field("first_is_aaaa", exp_r.first_is_aaaa, got.first_is_aaaa);
            compare_field("addr_high", exp_r.addr_high, got.addr_high);
            compare_field("addr_low", exp_r.addr_low, got.addr_low);
            compare_field("last", exp_r.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    dmp_in_t     req_item = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    dmp_out_t    rsp_item;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    parse_scoreboard sb = new();
    int  items_sent;
    int  messages_sent;
    bit  quiet;
    bit  start_hold;
    int  hold_left;
    int  stall_run;
    int  idle_cycles;

    always #5 clk = ~clk;

    dns_message_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_item);
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else if (start_hold)
        begin
            start_hold = 0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_run = gap_len() - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, sb.due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_byte(input logic c, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{cmd: c, data_byte: b};
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_byte(req_item);
        items_sent++;
    endtask

    task automatic push_name(ref logic [7:0] body[$], input bit long_name);
        int n, len;
        n = long_name ? 5 : $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            len = long_name ? $urandom_range(60, 63) : $urandom_range(1, 10);
            body.push_back(len[7:0]);
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
        end
        body.push_back(8'd0);
    endtask

    task automatic push16(ref logic [7:0] body[$], input logic [15:0] v);
        body.push_back(v[15:8]);
        body.push_back(v[7:0]);
    endtask

    task automatic send_message(input bit resp, input int flavor);
        logic [7:0]  body[$];
        logic [15:0] qd, an, ns, ar, qt, rtype, rdlen;
        logic [31:0] ttlv;
        int          sel, cut;
        bit          noisy;
        noisy = (flavor == FL_NOISY);
        qd = resp ? 16'd1 : 16'($urandom_range(0, 2));
        if (flavor == FL_NO_QUEST || (noisy && $urandom_range(0, 11) == 0))
            qd = resp ? 16'($urandom_range(0, 1) * 2) : 16'($urandom_range(0, 3));
        an = (flavor == FL_BAD_OWNER) ? 16'd2 : 16'($urandom_range(0, 3));
        ns = 16'($urandom_range(0, 1));
        ar = 16'($urandom_range(0, 1));
        repeat (4) body.push_back(8'($urandom_range(0, 255)));
        push16(body, qd);
        push16(body, an);
        push16(body, ns);
        push16(body, ar);
        push_name(body, flavor == FL_LONG_NAME);
        case ($urandom_range(0, 2))
            0: qt = sb.wanted;
            1: qt = TYPE_AAAA;
            default: qt = 16'($urandom_range(0, 65535));
        endcase
        push16(body, qt);
        push16(body, 16'($urandom_range(0, 65535)));
        if (resp)
        begin
            for (int r = 0; r < an + ns + ar; r++)
            begin
                sel = $urandom_range(0, 19);
                if ((flavor == FL_BAD_OWNER && r == 1) || (noisy && sel == 0))
                begin
                    body.push_back(8'($urandom_range(8'h40, 8'hBF)));
                end
                else if (sel < 11)
                begin
                    body.push_back(PTR_MARK | 8'($urandom_range(0, 63)));
                    body.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    push_name(body, 1'b0);
                end
                rtype = $urandom_range(0, 1) ? TYPE_AAAA : 16'($urandom_range(0, 65535));
                push16(body, rtype);
                push16(body, 16'($urandom_range(0, 65535)));
                case ($urandom_range(0, 4))
                    0: ttlv = 32'd0;
                    1: ttlv = 32'hFFFF_FFFF;
                    2: ttlv = 32'($urandom_range(1, 300));
                    default: ttlv = 32'($urandom());
                endcase
                push16(body, ttlv[31:16]);
                push16(body, ttlv[15:0]);
                if (rtype == TYPE_AAAA && $urandom_range(0, 3) != 0)
                    rdlen = 16'd16;
                else
                    rdlen = 16'($urandom_range(0, 12));
                push16(body, rdlen);
                repeat (rdlen) body.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (noisy && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
        if (flavor == FL_TRUNCATE || (noisy && $urandom_range(0, 9) == 0))
        begin
            cut = $urandom_range(1, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
        end
        send_byte(resp, 8'(body.size() >> 8));
        send_byte(1'($urandom_range(0, 1)), 8'(body.size()));
        foreach (body[i])
            send_byte(1'($urandom_range(0, 1)), body[i]);
        messages_sent++;
    endtask

    // Hold the sender, drain every expected result, then let the pipe settle.
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_wanted(input logic [15:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        sb.wanted = v;
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] settings[4];
        int          goal;
        settings = '{WANTED_QTYPE_RST, 16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535))};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, then clean, bad-owner, long-name, truncated and no-question messages.
        send_byte(CMD_RESPONSE, 8'h00);
        send_byte(CMD_REQUEST, 8'h00);
        send_message(CMD_REQUEST, FL_CLEAN);
        send_message(CMD_RESPONSE, FL_CLEAN);
        send_message(CMD_RESPONSE, FL_BAD_OWNER);
        send_message(CMD_REQUEST, FL_LONG_NAME);
        send_message(CMD_RESPONSE, FL_LONG_NAME);
        send_message(CMD_RESPONSE, FL_TRUNCATE);
        send_message(CMD_RESPONSE, FL_NO_QUEST);

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph > 0)
                write_wanted(settings[ph]);
            quiet = (ph == 1);
            if (ph == 2)
                start_hold = 1;
            goal = (ITEM_TARGET * (ph + 1)) / 4;
            while (items_sent < goal)
                send_message(1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0 ? FL_NOISY : FL_CLEAN);
        end
        quiet = 0;
        wait_idle();

        $display("sent %0d bytes in %0d messages over 4 qtype settings", items_sent,
                 messages_sent);
        $display("checked %0d record results and %0d final results", sb.records_seen,
                 sb.finals_seen);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- dns_message_parser.f -----
rtl/dmp_pkg.sv
rtl/dns_message_parser.sv
tb/testbench.sv
